>>> hdl/cdsr_pkg.sv
// Package for the character display shadow refresh core.
// Holds geometry constants, command/op codes, result and control structs.
// Has no dependencies.
package cdsr_pkg;

  localparam int COLUMNS   = 16;
  localparam int ROWS      = 2;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int CELL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PTR_W     = $clog2(CELLS + 1);
  localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OUT_COL_W = 4;
  localparam int OUT_ROW_W = 1;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] SHADOW_INIT = 8'hFF;

  typedef enum logic [2:0] {
    CMD_SET_POS = 3'd0,
    CMD_PUT     = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_FLUSH   = 3'd3,
    CMD_REFRESH = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_MOVE  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLR,
    ST_CELL,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic [7:0]           ch;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic [7:0]        data;
  } put_t;

  typedef struct packed {
    logic start_clear;
    logic start_flush;
    logic force_full;
  } seq_req_t;

endpackage

>>> hdl/cdsr_cell_store.sv
// Text store and shadow store, one read port each at the scan index.
// Per-entry valid bits give the reset contents; uses cdsr_pkg.
module cdsr_cell_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cdsr_pkg::put_t            put,
  input  logic                      clear,
  input  logic [cdsr_pkg::CELL_W-1:0] rd_addr,
  input  logic                      shadow_we,
  output logic [7:0]                text_rd,
  output logic [7:0]                shadow_rd
);
  import cdsr_pkg::*;

  logic [7:0] text_r     [CELLS];
  logic [7:0] shadow_r   [CELLS];
  logic [CELLS-1:0] text_vld_r;
  logic [CELLS-1:0] shadow_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_vld_r   <= '0;
      shadow_vld_r <= '0;
    end else begin
      if (clear) begin
        text_vld_r <= '0;
      end else if (put.we) begin
        text_vld_r[put.addr] <= 1'b1;
      end
      if (shadow_we) begin
        shadow_vld_r[rd_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put.we) begin
      text_r[put.addr] <= put.data;
    end
    if (shadow_we) begin
      shadow_r[rd_addr] <= text_rd;
    end
  end

  assign text_rd   = text_vld_r[rd_addr]   ? text_r[rd_addr]   : CHAR_SPACE;
  assign shadow_rd = shadow_vld_r[rd_addr] ? shadow_r[rd_addr] : SHADOW_INIT;

endmodule

>>> hdl/cdsr_flush_seq.sv
// Flush sequencer, uses cdsr_pkg: one cell per cycle bar moves/stalls, through a
// shared compare; emits display commands via a hold stage and output register.
module cdsr_flush_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdsr_pkg::seq_req_t          req,
  output logic                        idle,
  output logic [cdsr_pkg::CELL_W-1:0] rd_addr,
  input  logic [7:0]                  text_rd,
  input  logic [7:0]                  shadow_rd,
  output logic                        shadow_we,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cdsr_pkg::result_t           out_res
);
  import cdsr_pkg::*;

  state_t            state_r, state_nxt;
  logic              full_r, full_nxt;
  logic              refresh_all_r, refresh_all_nxt;
  logic              in_run_r, in_run_nxt;
  logic [CELL_W-1:0] idx_r, idx_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              hold_v_r;
  result_t           hold_r;
  logic              out_v_r;
  result_t           out_r;

  logic    eff_diff, last_cell, gen_want, gen_fire, done, out_free, hold_move;
  result_t gen;
  result_t hold_out;

  assign eff_diff  = full_r || (text_rd != shadow_rd);
  assign last_cell = (row_r == ROW_W'(ROWS - 1)) && (col_r == COL_W'(COLUMNS - 1));
  assign out_free  = !out_v_r || out_ready;
  assign gen_fire  = gen_want && (!hold_v_r || out_free);
  assign hold_move = hold_v_r && out_free && (gen_want || done);

  always_comb begin
    hold_out      = hold_r;
    hold_out.last = done;
  end

  always_comb begin
    state_nxt       = state_r;
    full_nxt        = full_r;
    refresh_all_nxt = refresh_all_r;
    in_run_nxt      = in_run_r;
    idx_nxt         = idx_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    gen_want        = 1'b0;
    done            = 1'b0;
    shadow_we       = 1'b0;
    gen             = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (req.start_clear) begin
          refresh_all_nxt = 1'b1;
          state_nxt       = ST_CLR;
        end else if (req.start_flush) begin
          full_nxt        = refresh_all_r || req.force_full;
          refresh_all_nxt = refresh_all_r || req.force_full;
          in_run_nxt      = 1'b0;
          idx_nxt         = '0;
          col_nxt         = '0;
          row_nxt         = '0;
          state_nxt       = ST_CELL;
        end
      end
      ST_CLR: begin
        gen_want = 1'b1;
        gen.op   = OP_CLEAR;
        if (gen_fire) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_CELL: begin
        if (eff_diff && !in_run_r) begin
          gen_want = 1'b1;
          gen.op   = OP_MOVE;
          gen.col  = OUT_COL_W'(col_r);
          gen.row  = OUT_ROW_W'(row_r);
          if (gen_fire) begin
            in_run_nxt = 1'b1;
          end
        end else begin
          if (eff_diff) begin
            gen_want  = 1'b1;
            gen.op    = OP_WRITE;
            gen.ch    = text_rd;
            shadow_we = gen_fire;
          end else begin
            in_run_nxt = 1'b0;
          end
          if (gen_fire || !eff_diff) begin
            idx_nxt = idx_r + CELL_W'(1);
            if (col_r == COL_W'(COLUMNS - 1)) begin
              col_nxt    = '0;
              row_nxt    = row_r + ROW_W'(1);
              in_run_nxt = 1'b0;
            end else begin
              col_nxt = col_r + COL_W'(1);
            end
            if (last_cell) begin
              if (full_r) begin
                refresh_all_nxt = 1'b0;
              end
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        done = 1'b1;
        if (!hold_v_r || hold_move) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      refresh_all_r <= 1'b1;
      full_r        <= 1'b0;
      in_run_r      <= 1'b0;
      idx_r         <= '0;
      col_r         <= '0;
      row_r         <= '0;
      hold_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      refresh_all_r <= refresh_all_nxt;
      full_r        <= full_nxt;
      in_run_r      <= in_run_nxt;
      idx_r         <= idx_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      if (gen_fire) begin
        hold_v_r <= 1'b1;
      end else if (hold_move) begin
        hold_v_r <= 1'b0;
      end
      if (hold_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      hold_r <= gen;
    end
    if (hold_move) begin
      out_r <= hold_out;
    end
  end

  assign idle      = (state_r == ST_IDLE);
  assign rd_addr   = idx_r;
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !hold_v_r)
    else $error("hold stage occupied while idle");

  a_idle_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !in_run_r)
    else $error("run flag left set after scan");

  a_clear_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.op == OP_CLEAR |-> out_r.last)
    else $error("clear-display transfer not marked last");

  a_full_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CELL && state_nxt == ST_DRAIN && full_r |=> !refresh_all_r)
    else $error("full refresh still armed after full pass");

endmodule

>>> hdl/char_display_shadow_refresh_core.sv
// Top level of the character display shadow refresh core.
// Decodes commands, keeps the write pointer; instantiates cdsr_cell_store and
// cdsr_flush_seq. Uses cdsr_pkg.
//
// Set position, put char and unused codes leave the core idle. Clear
// yields one clear-display transfer. A flush or forced refresh scans the
// store one cell per cycle, except when a cursor move is issued or the
// result side stalls, through a single compare in the flush sequencer.
// Clear and flush both take longer while the result side stalls. Input is
// not ready during a clear or a flush. The stores reset through per-entry
// valid bits, so no clearing pass follows reset.
module char_display_shadow_refresh_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_col,
  input  logic [7:0] in_row,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_op,
  output logic [3:0] out_col_res,
  output logic [0:0] out_row_res,
  output logic [7:0] out_char_code_res,
  output logic       out_last
);
  import cdsr_pkg::*;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic             pv_r, pv_nxt;
  logic             accept, idle, clear, shadow_we;
  logic [CELL_W-1:0] rd_addr;
  logic [7:0]       text_rd, shadow_rd;
  put_t             put;
  seq_req_t         req;
  result_t          res;

  assign in_ready = idle;
  assign accept   = in_valid && in_ready;

  always_comb begin
    wp_nxt = wp_r;
    pv_nxt = pv_r;
    put    = '0;
    clear  = 1'b0;
    req    = '0;
    if (accept) begin
      unique case (in_cmd)
        CMD_SET_POS: begin
          if (in_col < 8'(COLUMNS) && in_row < 8'(ROWS)) begin
            wp_nxt = PTR_W'(in_row[ROW_W-1:0]) * PTR_W'(COLUMNS)
                   + PTR_W'(in_col[COL_W-1:0]);
            pv_nxt = 1'b1;
          end else begin
            pv_nxt = 1'b0;
          end
        end
        CMD_PUT: begin
          if (pv_r && wp_r < PTR_W'(CELLS)) begin
            put.we   = 1'b1;
            put.addr = wp_r[CELL_W-1:0];
            put.data = in_char_code;
            wp_nxt   = wp_r + PTR_W'(1);
          end
        end
        CMD_CLEAR: begin
          clear           = 1'b1;
          req.start_clear = 1'b1;
        end
        CMD_FLUSH: begin
          req.start_flush = 1'b1;
        end
        CMD_REFRESH: begin
          req.start_flush = 1'b1;
          req.force_full  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      pv_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt;
      pv_r <= pv_nxt;
    end
  end

  cdsr_cell_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .put       (put),
    .clear     (clear),
    .rd_addr   (rd_addr),
    .shadow_we (shadow_we),
    .text_rd   (text_rd),
    .shadow_rd (shadow_rd)
  );

  cdsr_flush_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .idle      (idle),
    .rd_addr   (rd_addr),
    .text_rd   (text_rd),
    .shadow_rd (shadow_rd),
    .shadow_we (shadow_we),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_op            = res.op;
  assign out_col_res       = res.col;
  assign out_row_res       = res.row;
  assign out_char_code_res = res.ch;
  assign out_last          = res.last;

endmodule
